/* hw/rtl/sobol_sample_scrambled_defines.svh */
// Assertion macros shared by the scrambled Sobol sample generator.
// Depends on nothing; included by the top level, the only file that carries assertions.
`ifndef SOBOL_SAMPLE_SCRAMBLED_DEFINES_SVH
`define SOBOL_SAMPLE_SCRAMBLED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOBOL_SS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sobol_ss: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOBOL_SS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sobol_ss: next-cycle check failed");

`endif

/* hw/rtl/sobol_ss_pkg.sv */
// Package for the scrambled Sobol sample generator.
// Holds sizes, function codes, register indexes and hash constants; depends on nothing.
package sobol_ss_pkg;

	// Direction words per dimension and default dimension count.
	localparam int SEQ_BITS           = 32;
	localparam int DIMENSIONS_DEFAULT = 64;

	// Field widths.
	localparam int WORD_W    = 32;
	localparam int DIM_W     = 6;
	localparam int BIT_W     = 5;
	localparam int CFG_IDX_W = 3;

	// Input function codes.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PASS_OFFSET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ODD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_EVEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_NOISE_ON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SEED     = 3'd4;

	// Hash constants.
	localparam logic [WORD_W-1:0] MIX_MUL1  = 32'h7feb352d;
	localparam logic [WORD_W-1:0] MIX_MUL2  = 32'h846ca68b;
	localparam logic [WORD_W-1:0] DIM_GOLD  = 32'h9e3779b9;
	localparam logic [WORD_W-1:0] DIM_ADD   = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] ROT_SALT  = 32'hc2b2ae35;

endpackage

/* hw/rtl/sobol_ss_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sobol_ss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/sobol_sample_scrambled.sv */
// Scrambled Sobol sample generator: top level with sequencer and shared multiplier.
// Depends on sobol_ss_pkg, sobol_ss_ram and sobol_sample_scrambled_defines.svh.
//
// Usage:
// The input channel (in_valid / in_stall) carries load and sample transactions.
// A load (func = 0) writes one direction word into the table in the cycle it is
// accepted; the block is ready again in the next cycle.
// A sample (func = 1) walks the 32 direction words of its dimension through the
// table RAM, one read per cycle, XOR-accumulating those selected by the index
// bits. The xor-shift-multiply hashes for blue-noise mode run on the one shared
// 32x32 multiplier in parallel with the table walk and finish well before it.
// The result passes through the states READ (the 32 reads), LAST (the last RAM word
// is accumulated) and DONE (the final rotation add into the output register).
// A new sample is not taken before the last one is through; in_stall stays high
// from acceptance until the result is stored. The output register holds one
// result; a new transaction is accepted while it waits. If the receiver stalls,
// a finished sample waits in the sequencer until the output register is free,
// keeping in_stall high. Reset clears the sequencer, the output valid and all
// configuration registers. The direction table has no reset and must be loaded
// before it is sampled. Configuration writes (cfg_we) take effect at once; the
// user is to make them only while idle, which the block itself does not enforce.
`include "sobol_sample_scrambled_defines.svh"

module sobol_sample_scrambled #(
	parameter int DIMENSIONS = sobol_ss_pkg::DIMENSIONS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [sobol_ss_pkg::DIM_W-1:0]      dim,
	input  logic [sobol_ss_pkg::BIT_W-1:0]      bit_pos,
	input  logic [sobol_ss_pkg::WORD_W-1:0]     dir_word,
	input  logic [sobol_ss_pkg::WORD_W-1:0]     pass_num,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sobol_ss_pkg::WORD_W-1:0]     sample,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [sobol_ss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sobol_ss_pkg::WORD_W-1:0]     cfg_data
);

	localparam int DEPTH = DIMENSIONS * sobol_ss_pkg::SEQ_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = sobol_ss_pkg::DIM_W;
	localparam int BW    = sobol_ss_pkg::BIT_W;
	localparam int WW    = sobol_ss_pkg::WORD_W;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Hash step codes.
	localparam logic [3:0] HS_DIM_MUL  = 4'd0;
	localparam logic [3:0] HS_SEED_MIX = 4'd1;
	localparam logic [3:0] HS_K_MUL1   = 4'd2;
	localparam logic [3:0] HS_K_SHR15  = 4'd3;
	localparam logic [3:0] HS_K_MUL2   = 4'd4;
	localparam logic [3:0] HS_K_FINAL  = 4'd5;
	localparam logic [3:0] HS_R_MUL1   = 4'd6;
	localparam logic [3:0] HS_R_SHR15  = 4'd7;
	localparam logic [3:0] HS_R_MUL2   = 4'd8;
	localparam logic [3:0] HS_R_FINAL  = 4'd9;
	localparam logic [3:0] HS_DONE     = 4'd10;

	// Configuration registers.
	logic [WW-1:0] pass_offset_q;
	logic [WW-1:0] rotation_odd_q;
	logic [WW-1:0] rotation_even_q;
	logic          blue_noise_on_q;
	logic [WW-1:0] blue_noise_seed_q;

	// Sequencer and datapath registers.
	logic [1:0]    state_q;
	logic [BW-1:0] rd_q;
	logic          rdv_s1;
	logic [BW-1:0] j_s1;
	logic [DW-1:0] dim_q;
	logic          dim_ok_q;
	logic [WW-1:0] idx_q;
	logic [WW-1:0] rot_q;
	logic [WW-1:0] acc_q;
	logic [3:0]    hs_q;
	logic [WW-1:0] hq_q;
	logic [WW-1:0] k_q;
	logic          out_valid_q;
	logic [WW-1:0] sample_q;

	logic          in_acc;
	logic          dim_ok;
	logic          out_free;
	logic [AW+DW-1:0] waddr_full;
	logic [AW+DW-1:0] raddr_full;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          ram_we;
	logic [WW-1:0] rdata;
	logic [WW-1:0] mul_a;
	logic [WW-1:0] mul_b;
	logic [2*WW-1:0] mul_p;
	logic [WW-1:0] mix_t;
	logic [WW-1:0] k_next;
	logic [WW-1:0] salt_t;
	logic [WW-1:0] value;
	logic [WW-1:0] rot_final;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign dim_ok    = ({{(32-DW){1'b0}}, dim} < 32'(DIMENSIONS));

	// Configuration register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_offset_q     <= '0;
			rotation_odd_q    <= '0;
			rotation_even_q   <= '0;
			blue_noise_on_q   <= 1'b0;
			blue_noise_seed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sobol_ss_pkg::REG_PASS_OFFSET:   pass_offset_q     <= cfg_data;
				sobol_ss_pkg::REG_ROTATION_ODD:  rotation_odd_q    <= cfg_data;
				sobol_ss_pkg::REG_ROTATION_EVEN: rotation_even_q   <= cfg_data;
				sobol_ss_pkg::REG_BLUE_NOISE_ON: blue_noise_on_q   <= cfg_data[0];
				sobol_ss_pkg::REG_BLUE_SEED:     blue_noise_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table addresses: dimension times 32 plus bit position.
	assign waddr_full = ({{AW{1'b0}}, dim} << BW) | {{(AW+DW-BW){1'b0}}, bit_pos};
	assign raddr_full = ({{AW{1'b0}}, dim_q} << BW) | {{(AW+DW-BW){1'b0}}, rd_q};
	assign waddr      = waddr_full[AW-1:0];
	assign raddr      = raddr_full[AW-1:0];
	assign ram_we     = in_acc && (func == sobol_ss_pkg::FUNC_LOAD) && dim_ok;

	sobol_ss_ram #(
		.WIDTH(WW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(dir_word),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Shared multiplier operand selection; only the low word is kept.
	always_comb begin
		mul_a = hq_q;
		mul_b = sobol_ss_pkg::MIX_MUL2;
		case (hs_q)
			HS_DIM_MUL: begin
				mul_a = {{(WW-DW){1'b0}}, dim_q};
				mul_b = sobol_ss_pkg::DIM_GOLD;
			end
			HS_K_MUL1, HS_R_MUL1: mul_b = sobol_ss_pkg::MIX_MUL1;
			default: mul_b = sobol_ss_pkg::MIX_MUL2;
		endcase
	end
	assign mul_p  = mul_a * mul_b;
	assign mix_t  = blue_noise_seed_q ^ (hq_q + sobol_ss_pkg::DIM_ADD);
	assign k_next = hq_q ^ (hq_q >> 16);
	assign salt_t = k_next ^ sobol_ss_pkg::ROT_SALT;

	// Final combination of the Sobol value with scramble and rotation.
	assign value     = blue_noise_on_q ? (acc_q ^ k_q) : acc_q;
	assign rot_final = blue_noise_on_q ? hq_q : rot_q;

	// Hash sequencer: one step per cycle, runs alongside the table walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HS_DONE;
		end else if (in_acc && (func == sobol_ss_pkg::FUNC_SAMPLE)) begin
			hs_q <= HS_DIM_MUL;
		end else if (hs_q != HS_DONE) begin
			hs_q <= hs_q + 4'd1;
		end
	end

	// Hash datapath; each multiply lands in a register.
	always_ff @(posedge clk) begin
		case (hs_q)
			HS_DIM_MUL, HS_K_MUL1, HS_K_MUL2, HS_R_MUL1, HS_R_MUL2: begin
				hq_q <= mul_p[WW-1:0];
			end
			HS_SEED_MIX: hq_q <= mix_t ^ (mix_t >> 16);
			HS_K_SHR15, HS_R_SHR15: hq_q <= hq_q ^ (hq_q >> 15);
			HS_K_FINAL: begin
				k_q  <= k_next;
				hq_q <= salt_t ^ (salt_t >> 16);
			end
			HS_R_FINAL: hq_q <= k_next;
			default: ;
		endcase
	end

	// Main sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_q        <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_READ);
			// A finished sample fills the output register; an accepted one leaves it.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (func == sobol_ss_pkg::FUNC_SAMPLE)) begin
						state_q <= ST_READ;
						rd_q    <= '0;
					end
				end
				ST_READ: begin
					rd_q <= rd_q + 1'b1;
					if (rd_q == {BW{1'b1}}) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample datapath: capture at acceptance, accumulate, produce result.
	always_ff @(posedge clk) begin
		j_s1 <= rd_q;
		if (in_acc && (func == sobol_ss_pkg::FUNC_SAMPLE)) begin
			dim_q    <= dim;
			dim_ok_q <= dim_ok;
			acc_q    <= '0;
			idx_q    <= blue_noise_on_q ? pass_num : (pass_num + pass_offset_q);
			rot_q    <= dim[0] ? rotation_odd_q : rotation_even_q;
		end else if (rdv_s1 && dim_ok_q && idx_q[j_s1]) begin
			acc_q <= acc_q ^ rdata;
		end
		if ((state_q == ST_DONE) && out_free) begin
			sample_q <= value + rot_final;
		end
	end

	// Checks on the sequencer.
	`SOBOL_SS_ASSERT_NEXT(a_read_to_last, clk, arst_n,
		(state_q == ST_READ) && (rd_q == {BW{1'b1}}), state_q == ST_LAST)
	`SOBOL_SS_ASSERT_IMPLY(a_last_read_word, clk, arst_n,
		state_q == ST_LAST, rdv_s1 && (j_s1 == {BW{1'b1}}))
	`SOBOL_SS_ASSERT_IMPLY(a_hash_done, clk, arst_n,
		state_q == ST_DONE, hs_q == HS_DONE)
	`SOBOL_SS_ASSERT_NEXT(a_sample_start, clk, arst_n,
		in_acc && (func == sobol_ss_pkg::FUNC_SAMPLE),
		(state_q == ST_READ) && (rd_q == '0) && (acc_q == '0))
	`SOBOL_SS_ASSERT_NEXT(a_result_out, clk, arst_n,
		(state_q == ST_DONE) && out_free, out_valid && (state_q == ST_IDLE))

endmodule
